[hdl/assert_macros.svh]
// Assertion macros shared by the turn radius limiter RTL.
// Expects signals clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never be true on an active clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// ante implies cons on the same edge
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[hdl/trl_pkg.sv]
// Shared constants, types and helpers for the turn radius limiter.
// No dependencies; used by trl_front, trl_div and turn_radius_limiter_core.
package trl_pkg;

    localparam int VEL_WIDTH     = 16;
    localparam int VEL_FRAC_BITS = 8;
    localparam int RADIUS_FRAC   = 8;
    localparam int GAIN_W        = 16;
    localparam int RADIUS_W      = 24;

    localparam int GPROD_W  = GAIN_W + VEL_WIDTH;
    localparam int RSUM_W   = GPROD_W - VEL_FRAC_BITS + 1;
    localparam int VSC_W    = VEL_WIDTH + RADIUS_FRAC;
    localparam int RW_W     = RADIUS_W + VEL_WIDTH;
    localparam int QUOT_W   = VEL_WIDTH - 1;
    localparam int DIV_W    = RADIUS_W + QUOT_W;

    localparam int S_TDATA_W = ((2 * VEL_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((VEL_WIDTH + QUOT_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = GAIN_W;

    localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;
    localparam logic [QUOT_W-1:0]   ANG_SAT    = '1;
    localparam logic [GAIN_W-1:0]   BASE_RADIUS_RST = GAIN_W'(256);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ENABLE      = 2'd0,
        CFG_BASE_RADIUS = 2'd1,
        CFG_SPEED_DEP   = 2'd2,
        CFG_SPEED_GAIN  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic              enable;
        logic [GAIN_W-1:0] base_radius;
        logic              speed_dep;
        logic [GAIN_W-1:0] speed_gain;
    } cfg_t;

    // per-item flags carried alongside the divider
    typedef struct packed {
        logic [VEL_WIDTH-1:0] w_raw;
        logic                 w_neg;
        logic                 clamp;
        logic                 unlimited;
        logic                 sat;
    } side_t;

    typedef struct packed {
        side_t                side;
        logic [RADIUS_W-1:0]  radius;
        logic [VSC_W-1:0]     num;
    } div_item_t;

    typedef struct packed {
        side_t               side;
        logic [QUOT_W-1:0]   quot;
    } div_res_t;

    // magnitude of a two's complement velocity; most negative maps to 2^(W-1)
    function automatic logic [VEL_WIDTH-1:0] vel_mag(input logic [VEL_WIDTH-1:0] raw);
        return raw[VEL_WIDTH-1] ? (~raw + VEL_WIDTH'(1)) : raw;
    endfunction

endpackage

[hdl/trl_front.sv]
// Front pipeline: magnitudes, effective radius, radius*|w| and quotient overflow test.
// Four register stages; depends on trl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module trl_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  trl_pkg::cfg_t                  cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [trl_pkg::VEL_WIDTH-1:0]  linear_in,
    input  logic [trl_pkg::VEL_WIDTH-1:0]  angular_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output trl_pkg::div_item_t             out_item
);

    // stage 1: magnitudes and gain*|v|
    logic                           s1_valid_reg;
    logic [trl_pkg::VEL_WIDTH-1:0]  s1_vmag_reg;
    logic [trl_pkg::VEL_WIDTH-1:0]  s1_wmag_reg;
    logic [trl_pkg::VEL_WIDTH-1:0]  s1_wraw_reg;
    logic [trl_pkg::GPROD_W-1:0]    s1_gprod_reg;
    // stage 2: effective radius
    logic                           s2_valid_reg;
    logic [trl_pkg::VEL_WIDTH-1:0]  s2_vmag_reg;
    logic [trl_pkg::VEL_WIDTH-1:0]  s2_wmag_reg;
    logic [trl_pkg::VEL_WIDTH-1:0]  s2_wraw_reg;
    logic [trl_pkg::RADIUS_W-1:0]   s2_radius_reg;
    // stage 3: radius*|w| and overflow test
    logic                           s3_valid_reg;
    logic [trl_pkg::VEL_WIDTH-1:0]  s3_vmag_reg;
    logic [trl_pkg::VEL_WIDTH-1:0]  s3_wraw_reg;
    logic [trl_pkg::RADIUS_W-1:0]   s3_radius_reg;
    logic [trl_pkg::RW_W-1:0]       s3_rw_reg;
    logic                           s3_wnz_reg;
    logic                           s3_sat_reg;
    logic                           s3_unlim_reg;
    // stage 4: clamp decision
    logic                           s4_valid_reg;
    trl_pkg::div_item_t             s4_item_reg;

    logic en1, en2, en3, en4;

    logic [trl_pkg::RSUM_W-1:0]    rsum;
    logic [trl_pkg::RADIUS_W-1:0]  radius_next;
    logic [trl_pkg::VSC_W-1:0]     s2_vsc;
    logic [trl_pkg::VSC_W-1:0]     s3_vsc;
    trl_pkg::div_item_t            item_next;

    assign en4 = !s4_valid_reg || out_ready;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        rsum = trl_pkg::RSUM_W'(cfg.base_radius)
             + trl_pkg::RSUM_W'(s1_gprod_reg >> trl_pkg::VEL_FRAC_BITS);
        if (!cfg.speed_dep)
        begin
            radius_next = trl_pkg::RADIUS_W'(cfg.base_radius);
        end
        else if (rsum > trl_pkg::RSUM_W'(trl_pkg::RADIUS_MAX))
        begin
            radius_next = trl_pkg::RADIUS_MAX;
        end
        else
        begin
            radius_next = rsum[trl_pkg::RADIUS_W-1:0];
        end
    end

    assign s2_vsc = {s2_vmag_reg, trl_pkg::RADIUS_FRAC'(0)};
    assign s3_vsc = {s3_vmag_reg, trl_pkg::RADIUS_FRAC'(0)};

    always_comb
    begin
        item_next.side.w_raw     = s3_wraw_reg;
        item_next.side.w_neg     = s3_wraw_reg[trl_pkg::VEL_WIDTH-1];
        item_next.side.clamp     = cfg.enable && s3_wnz_reg
                                 && (trl_pkg::RW_W'(s3_vsc) < s3_rw_reg);
        item_next.side.unlimited = s3_unlim_reg;
        item_next.side.sat       = s3_sat_reg;
        item_next.radius         = s3_radius_reg;
        item_next.num            = s3_vsc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) s1_valid_reg <= in_valid;
            if (en2) s2_valid_reg <= s1_valid_reg;
            if (en3) s3_valid_reg <= s2_valid_reg;
            if (en4) s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            s1_vmag_reg  <= trl_pkg::vel_mag(linear_in);
            s1_wmag_reg  <= trl_pkg::vel_mag(angular_in);
            s1_wraw_reg  <= angular_in;
            s1_gprod_reg <= trl_pkg::GPROD_W'(cfg.speed_gain)
                          * trl_pkg::GPROD_W'(trl_pkg::vel_mag(linear_in));
        end
        if (en2 && s1_valid_reg)
        begin
            s2_vmag_reg   <= s1_vmag_reg;
            s2_wmag_reg   <= s1_wmag_reg;
            s2_wraw_reg   <= s1_wraw_reg;
            s2_radius_reg <= radius_next;
        end
        if (en3 && s2_valid_reg)
        begin
            s3_vmag_reg   <= s2_vmag_reg;
            s3_wraw_reg   <= s2_wraw_reg;
            s3_radius_reg <= s2_radius_reg;
            s3_rw_reg     <= trl_pkg::RW_W'(s2_radius_reg) * trl_pkg::RW_W'(s2_wmag_reg);
            s3_wnz_reg    <= (s2_wmag_reg != '0);
            // quotient would not fit in QUOT_W bits
            s3_sat_reg    <= (trl_pkg::DIV_W'(s2_vsc)
                              >= (trl_pkg::DIV_W'(s2_radius_reg) << trl_pkg::QUOT_W));
            s3_unlim_reg  <= !cfg.enable || (s2_radius_reg == '0);
        end
        if (en4 && s3_valid_reg)
        begin
            s4_item_reg <= item_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_item  = s4_item_reg;

    `ASSERT_NEVER(a_front_clamp_zero_radius,
        s4_valid_reg && s4_item_reg.side.clamp && (s4_item_reg.radius == '0),
        "clamp raised with zero effective radius")

endmodule

[hdl/trl_div.sv]
// Restoring divider, one quotient bit per register stage, (|v|<<8) / radius.
// Carries the per-item flags alongside; depends on trl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module trl_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  trl_pkg::div_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output trl_pkg::div_res_t   out_res
);

    localparam int LAST = trl_pkg::QUOT_W - 1;

    logic                           valid_reg  [trl_pkg::QUOT_W];
    logic [trl_pkg::VSC_W-1:0]      rem_reg    [trl_pkg::QUOT_W];
    logic [trl_pkg::QUOT_W-1:0]     quot_reg   [trl_pkg::QUOT_W];
    logic [trl_pkg::RADIUS_W-1:0]   radius_reg [trl_pkg::QUOT_W];
    trl_pkg::side_t                 side_reg   [trl_pkg::QUOT_W];
    logic [trl_pkg::QUOT_W-1:0]     en;

    for (genvar s = 0; s < trl_pkg::QUOT_W; s++)
    begin : g_stage
        localparam int BIT = trl_pkg::QUOT_W - 1 - s;

        logic                          vin;
        logic [trl_pkg::VSC_W-1:0]     rin;
        logic [trl_pkg::QUOT_W-1:0]    qin;
        logic [trl_pkg::RADIUS_W-1:0]  din;
        trl_pkg::side_t                sin;
        logic                          en_dn;
        logic [trl_pkg::DIV_W-1:0]     shifted;
        logic [trl_pkg::DIV_W:0]       trial;
        logic                          take;
        logic [trl_pkg::VSC_W-1:0]     rem_next;
        logic [trl_pkg::QUOT_W-1:0]    quot_next;

        if (s == 0)
        begin : g_first
            assign vin = in_valid;
            assign rin = in_item.num;
            assign qin = '0;
            assign din = in_item.radius;
            assign sin = in_item.side;
        end
        else
        begin : g_chain
            assign vin = valid_reg[s-1];
            assign rin = rem_reg[s-1];
            assign qin = quot_reg[s-1];
            assign din = radius_reg[s-1];
            assign sin = side_reg[s-1];
        end

        if (s == LAST)
        begin : g_tail
            assign en_dn = out_ready;
        end
        else
        begin : g_body
            assign en_dn = en[s+1];
        end

        assign en[s] = !valid_reg[s] || en_dn;

        assign shifted   = trl_pkg::DIV_W'(din) << BIT;
        assign trial     = {1'b0, trl_pkg::DIV_W'(rin)} - {1'b0, shifted};
        assign take      = !trial[trl_pkg::DIV_W];
        assign rem_next  = take ? trial[trl_pkg::VSC_W-1:0] : rin;
        assign quot_next = qin | (trl_pkg::QUOT_W'(take) << BIT);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en[s])
            begin
                valid_reg[s] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[s] && vin)
            begin
                rem_reg[s]    <= rem_next;
                quot_reg[s]   <= quot_next;
                radius_reg[s] <= din;
                side_reg[s]   <= sin;
            end
        end
    end

    assign in_ready       = en[0];
    assign out_valid      = valid_reg[LAST];
    assign out_res.side   = side_reg[LAST];
    assign out_res.quot   = quot_reg[LAST];

    `ASSERT_NEVER(a_div_rem_below_divisor,
        valid_reg[LAST] && !side_reg[LAST].sat && (rem_reg[LAST] >= radius_reg[LAST]),
        "divider remainder not below divisor")

endmodule

[hdl/turn_radius_limiter_core.sv]
// Top level of the turn radius limiter: configuration registers, front pipeline,
// divider and output register. Depends on trl_pkg, trl_front, trl_div, assert_macros.svh.
//
// Takes one (linear, angular) velocity item per cycle and returns one result per item,
// in order, after passing through 4 front stages
// (magnitudes and gain multiply, radius sum, radius*|w| multiply, clamp decision),
// 15 divider stages that each resolve one bit of the restoring division |v|*256 / R,
// and 1 output register. Sustained rate is one item per cycle. Stalls propagate stage
// by stage, so empty stages keep filling while the output waits. Configuration is
// always ready and must only change while no item is in flight.
`include "assert_macros.svh"

module turn_radius_limiter_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    // stream in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [trl_pkg::S_TDATA_W-1:0]     s_tdata,   // [15:0] linear_in, [31:16] angular_in
    // stream out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [trl_pkg::M_TDATA_W-1:0]     m_tdata,   // [15:0] angular_out, [30:16] max_angular
    output logic [trl_pkg::M_TUSER_W-1:0]     m_tuser,   // [0] clamped, [1] max_unlimited
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [trl_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [trl_pkg::CFG_DATA_W-1:0]    cfg_data
);

    trl_pkg::cfg_t cfg_reg;

    logic                front_valid;
    logic                front_ready;
    trl_pkg::div_item_t  front_item;
    logic                div_valid;
    logic                div_ready;
    trl_pkg::div_res_t   div_res;

    logic                              out_valid_reg;
    logic [trl_pkg::VEL_WIDTH-1:0]     out_ang_reg;
    logic [trl_pkg::QUOT_W-1:0]        out_max_reg;
    logic                              out_clamped_reg;
    logic                              out_unlim_reg;

    logic                              out_en;
    logic [trl_pkg::VEL_WIDTH-1:0]     ang_next;
    logic [trl_pkg::QUOT_W-1:0]        max_next;
    logic [trl_pkg::VEL_WIDTH-1:0]     out_ang_mag;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable      <= 1'b1;
            cfg_reg.base_radius <= trl_pkg::BASE_RADIUS_RST;
            cfg_reg.speed_dep   <= 1'b0;
            cfg_reg.speed_gain  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (trl_pkg::cfg_index_t'(cfg_index))
                trl_pkg::CFG_ENABLE:      cfg_reg.enable      <= cfg_data[0];
                trl_pkg::CFG_BASE_RADIUS: cfg_reg.base_radius <= cfg_data;
                trl_pkg::CFG_SPEED_DEP:   cfg_reg.speed_dep   <= cfg_data[0];
                trl_pkg::CFG_SPEED_GAIN:  cfg_reg.speed_gain  <= cfg_data;
            endcase
        end
    end

    trl_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .linear_in  (s_tdata[trl_pkg::VEL_WIDTH-1:0]),
        .angular_in (s_tdata[2*trl_pkg::VEL_WIDTH-1:trl_pkg::VEL_WIDTH]),
        .out_valid  (front_valid),
        .out_ready  (front_ready),
        .out_item   (front_item)
    );

    trl_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_res   (div_res)
    );

    assign out_en    = !out_valid_reg || m_tready;
    assign div_ready = out_en;

    always_comb
    begin
        // a clamped quotient is below |w|, so it never saturates
        if (div_res.side.clamp)
        begin
            ang_next = div_res.side.w_neg ? -trl_pkg::VEL_WIDTH'(div_res.quot)
                                          :  trl_pkg::VEL_WIDTH'(div_res.quot);
        end
        else
        begin
            ang_next = div_res.side.w_raw;
        end
        if (div_res.side.unlimited || div_res.side.sat)
        begin
            max_next = trl_pkg::ANG_SAT;
        end
        else
        begin
            max_next = div_res.quot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en && div_valid)
        begin
            out_ang_reg     <= ang_next;
            out_max_reg     <= max_next;
            out_clamped_reg <= div_res.side.clamp;
            out_unlim_reg   <= div_res.side.unlimited;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = trl_pkg::M_TDATA_W'({out_max_reg, out_ang_reg});
    assign m_tuser  = {out_unlim_reg, out_clamped_reg};

    assign out_ang_mag = trl_pkg::vel_mag(out_ang_reg);

    `ASSERT_IMPLY(a_clamp_not_unlimited,
        out_valid_reg && out_clamped_reg, !out_unlim_reg,
        "clamped result reports no angular limit")

    `ASSERT_NEVER(a_clamp_mag_is_limit,
        out_valid_reg && out_clamped_reg
            && (out_ang_mag != trl_pkg::VEL_WIDTH'(out_max_reg)),
        "clamped angular magnitude differs from reported limit")

endmodule

[sim/tb_top.sv]
// Self-checking testbench for turn_radius_limiter_core: drives velocity items
// and config writes, predicts each result and checks it on the output stream.
// Depends on trl_pkg and the turn_radius_limiter_core RTL.
module tb_top;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_SLACK  = 24;
    localparam int HOLD_CYCLES  = 200;
    localparam int MAX_REPORTS  = 10;
    localparam int SWEEP_PHASES = 8;
    localparam int SWEEP_ITEMS  = 180;

    typedef struct packed {
        logic [trl_pkg::VEL_WIDTH-1:0] angular;
        logic                          clamped;
        logic [trl_pkg::QUOT_W-1:0]    max_ang;
        logic                          unlimited;
    } limit_res_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [trl_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [trl_pkg::M_TDATA_W-1:0]   m_tdata;   // [15:0] angular_out, [30:16] max_angular
    logic [trl_pkg::M_TUSER_W-1:0]   m_tuser;   // [0] clamped, [1] max_unlimited
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [trl_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [trl_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    trl_pkg::cfg_t cfg_model;
    limit_res_t    pending_results[$];
    int            mismatches = 0;
    int            cycle_count = 0;
    bit            burst_mode = 1'b0;
    bit            hold_req = 1'b0;
    logic          sink_hold = 1'b0;
    int            sink_wait = 0;

    turn_radius_limiter_core u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // expected limiter output for one command under config c
    function automatic limit_res_t predict_limit(input logic [15:0] lin,
                                                 input logic [15:0] ang,
                                                 input trl_pkg::cfg_t c);
        bit [16:0]  vmag;
        bit [16:0]  wmag;
        bit [32:0]  gprod;
        bit [25:0]  rsum;
        bit [23:0]  radius;
        bit [24:0]  vsc;
        bit [40:0]  rw;
        bit [24:0]  quot;
        limit_res_t res;
        vmag = lin[15] ? 17'(17'h10000 - 17'(lin)) : 17'(lin);
        wmag = ang[15] ? 17'(17'h10000 - 17'(ang)) : 17'(ang);
        rsum = 26'(c.base_radius);
        if (c.speed_dep)
        begin
            gprod = 33'(c.speed_gain) * 33'(vmag);
            rsum  = rsum + 26'(gprod >> trl_pkg::VEL_FRAC_BITS);
            if (rsum > 26'(trl_pkg::RADIUS_MAX))
                rsum = 26'(trl_pkg::RADIUS_MAX);
        end
        radius = rsum[23:0];
        vsc    = 25'(vmag) << trl_pkg::RADIUS_FRAC;
        quot   = (radius != 0) ? vsc / 25'(radius) : 25'd0;
        res.angular   = ang;
        res.clamped   = 1'b0;
        res.max_ang   = trl_pkg::ANG_SAT;
        res.unlimited = 1'b1;
        if (c.enable && radius != 0)
        begin
            res.max_ang   = (quot > 25'(trl_pkg::ANG_SAT)) ? trl_pkg::ANG_SAT : quot[14:0];
            res.unlimited = 1'b0;
        end
        rw = 41'(radius) * 41'(wmag);
        if (c.enable && wmag != 0 && 41'(vsc) < rw)
        begin
            // quotient is below |w| here, so it fits 15 bits
            res.angular = ang[15] ? (~quot[15:0] + 16'd1) : quot[15:0];
            res.clamped = 1'b1;
        end
        return res;
    endfunction

    function automatic logic [15:0] rand_vel();
        logic [15:0] v;
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = 16'($urandom_range(0, 511));
            2: v = -16'($urandom_range(1, 511));
            3:
            begin
                case ($urandom_range(0, 3))
                    0: v = 16'h8000;
                    1: v = 16'h7FFF;
                    2: v = 16'h0001;
                    default: v = 16'hFFFF;
                endcase
            end
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    task automatic send_cmd(input logic [15:0] lin, input logic [15:0] ang);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ang, lin};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(predict_limit(lin, ang, cfg_model));
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic write_reg(input trl_pkg::cfg_index_t idx,
                             input logic [trl_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            trl_pkg::CFG_ENABLE:      cfg_model.enable      = data[0];
            trl_pkg::CFG_BASE_RADIUS: cfg_model.base_radius = data;
            trl_pkg::CFG_SPEED_DEP:   cfg_model.speed_dep   = data[0];
            trl_pkg::CFG_SPEED_GAIN:  cfg_model.speed_gain  = data;
            default: ;
        endcase
    endtask

    // single-bit registers get junk in the upper bits, which must be ignored
    task automatic write_config(input logic en, input logic [15:0] base,
                                input logic sd, input logic [15:0] gain);
        write_reg(trl_pkg::CFG_ENABLE, {15'($urandom), en});
        write_reg(trl_pkg::CFG_BASE_RADIUS, base);
        write_reg(trl_pkg::CFG_SPEED_DEP, {15'($urandom), sd});
        write_reg(trl_pkg::CFG_SPEED_GAIN, gain);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_radius_word();
        logic [15:0] r;
        case ($urandom_range(0, 4))
            0: r = 16'h0000;
            1: r = 16'hFFFF;
            2: r = 16'($urandom_range(1, 1023));
            default: r = 16'($urandom);
        endcase
        return r;
    endfunction

    task automatic random_config;
        write_config($urandom_range(0, 4) != 0, rand_radius_word(),
                     1'($urandom), rand_radius_word());
    endtask

    task automatic test_reset_defaults;
        // reset config: enabled, R = 1.0, no speed term
        send_cmd(16'h0000, 16'h0000);
        send_cmd(16'h0000, 16'h0100);     // v zero, w nonzero: clamps to zero
        send_cmd(16'h0100, 16'h0200);
        send_cmd(16'h0100, 16'hFE00);
        send_cmd(16'h8000, 16'h8000);     // most negative w, not clamped
        send_cmd(16'h7FFF, 16'h8000);     // most negative w, clamped
        send_cmd(16'h7FFF, 16'h7FFF);     // radius exactly at the limit
        send_cmd(16'h8000, 16'h7FFF);
        send_cmd(16'h0001, 16'h0001);
        drain();
    endtask

    task automatic test_special_configs;
        write_config(1'b0, 16'd256, 1'b0, 16'd0);
        send_cmd(16'd100, 16'd1000);
        send_cmd(16'h8000, 16'h8000);
        send_cmd(16'h0000, 16'h0005);
        drain();
        // zero radius never clamps
        write_config(1'b1, 16'd0, 1'b0, 16'hFFFF);
        send_cmd(16'h0000, 16'd1000);
        send_cmd(16'h7FFF, 16'h8000);
        send_cmd(16'h0000, 16'h0000);
        drain();
        // tiny radius saturates the allowed rate
        write_config(1'b1, 16'd1, 1'b1, 16'd0);
        send_cmd(16'h7FFF, 16'd100);
        send_cmd(16'h0001, 16'h7FFF);
        drain();
        // largest radius the registers allow
        write_config(1'b1, 16'hFFFF, 1'b1, 16'hFFFF);
        send_cmd(16'h8000, 16'h7FFF);
        send_cmd(16'h7FFF, 16'hFFFF);
        send_cmd(16'h0100, 16'h7FFF);
        drain();
    endtask

    task automatic test_random_sweep;
        for (int p = 0; p < SWEEP_PHASES; p++)
        begin
            case (p)
                0: write_config(1'b1, 16'hFFFF, 1'b1, 16'hFFFF);
                1: write_config(1'b1, 16'h0000, 1'b0, 16'h0000);
                2: write_config(1'b1, 16'h0000, 1'b1, 16'h0001);
                default: random_config();
            endcase
            for (int i = 0; i < SWEEP_ITEMS; i++)
                send_cmd(rand_vel(), rand_vel());
            drain();
        end
    endtask

    task automatic test_back_to_back;
        random_config();
        burst_mode = 1'b1;
        for (int i = 0; i < 100; i++)
            send_cmd(rand_vel(), rand_vel());
        drain();
        burst_mode = 1'b0;
    endtask

    task automatic test_output_stall;
        write_config(1'b1, rand_radius_word(), 1'b1, 16'($urandom_range(0, 4095)));
        hold_req   = 1'b1;
        burst_mode = 1'b1;
        for (int i = 0; i < 120; i++)
            send_cmd(rand_vel(), rand_vel());
        burst_mode = 1'b0;
        drain();
    endtask

    // long output hold-off, timed here so the sender keeps pushing meanwhile
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                sink_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                sink_hold <= 1'b0;
                hold_req = 1'b0;
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sink_wait = burst_mode ? 0 : $urandom_range(0, 9);
            if (sink_hold || sink_wait > 0)
            begin
                m_tready <= 1'b0;
                if (!sink_hold)
                    sink_wait--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        limit_res_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: tdata=%h tuser=%b", m_tdata, m_tuser);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (m_tdata[15:0] !== exp_res.angular || m_tdata[30:16] !== exp_res.max_ang ||
                    m_tdata[31] !== 1'b0 || m_tuser[0] !== exp_res.clamped ||
                    m_tuser[1] !== exp_res.unlimited)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("mismatch: exp ang=%h max=%h clamp=%b unlim=%b",
                                 exp_res.angular, exp_res.max_ang, exp_res.clamped,
                                 exp_res.unlimited);
                        $display("          got ang=%h max=%h clamp=%b unlim=%b pad=%b",
                                 m_tdata[15:0], m_tdata[30:16], m_tuser[0], m_tuser[1],
                                 m_tdata[31]);
                    end
                end
            end
        end
    end

    initial
    begin
        cfg_model.enable      = 1'b1;
        cfg_model.base_radius = trl_pkg::BASE_RADIUS_RST;
        cfg_model.speed_dep   = 1'b0;
        cfg_model.speed_gain  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_special_configs();
        test_random_sweep();
        test_back_to_back();
        test_output_stall();

        if (mismatches == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/trl_pkg.sv
hdl/trl_front.sv
hdl/trl_div.sv
hdl/turn_radius_limiter_core.sv
sim/tb_top.sv
